/* design/spq_pkg.sv */
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int HELD_W   = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQ   = 2'd0;
    localparam logic [1:0] ST_DEQ   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic signed [31:0] out_priority;
        logic [HELD_W-1:0]  held_count;
    } t_out_item;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load_item;
        logic exec;
    } t_ctl_cmd;

endpackage

/* design/spq_ctrl.sv */
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_ctl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !i_out_ready;
        o_in_ready      = 1'b0;
        o_cmd.load_item = 1'b0;
        o_cmd.exec      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                // result slot must be free before the queue updates
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/spq_datapath.sv */
module spq_datapath
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    input  t_in_item  i_in_item,
    output t_out_item o_out_item
);

    t_in_item           r_item;
    logic signed [31:0] r_val [CAPACITY];
    logic signed [31:0] r_pri [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_out_item          r_out;
    t_out_item          n_out;

    logic [CAPACITY-1:0] w_lt;
    logic                w_full;
    logic                w_empty;
    logic                w_do_enq;
    logic                w_do_deq;
    logic [CNT_W+HELD_W-1:0] w_held_ext;

    // per-slot compare, only over occupied slots
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_lt[i] = (CNT_W'(i) < r_count) && (r_pri[i] < r_item.item_priority);
        end
    end

    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_do_enq = (r_item.opcode == OP_ENQ) && !w_full;
    assign w_do_deq = (r_item.opcode == OP_DEQ) && !w_empty;

    always_comb begin
        n_count = r_count;
        if (w_do_enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_deq) begin
            n_count = r_count - CNT_W'(1);
        end
        w_held_ext = {{HELD_W{1'b0}}, n_count};
        n_out.held_count   = w_held_ext[HELD_W-1:0];
        n_out.out_value    = '0;
        n_out.out_priority = '0;
        if (r_item.opcode == OP_ENQ) begin
            n_out.status = w_full ? ST_FULL : ST_ENQ;
        end else if (w_empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.status       = ST_DEQ;
            n_out.out_value    = r_val[0];
            n_out.out_priority = r_pri[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    // compare-and-shift across all slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_do_enq) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (!w_lt[i]) begin
                    if (i == 0) begin
                        r_val[i] <= r_item.item_value;
                        r_pri[i] <= r_item.item_priority;
                    end else if (w_lt[i-1]) begin
                        r_val[i] <= r_item.item_value;
                        r_pri[i] <= r_item.item_priority;
                    end else begin
                        r_val[i] <= r_val[i-1];
                        r_pri[i] <= r_pri[i-1];
                    end
                end
            end
        end else if (i_cmd.exec && w_do_deq) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                r_val[i] <= r_val[i+1];
                r_pri[i] <= r_pri[i+1];
            end
        end
    end

    assign o_out_item = r_out;

endmodule

/* design/sorted_priority_queue.sv */
// Sorted priority queue holding up to CAPACITY (value, signed priority) entries in
// ascending priority order; a dequeue returns the smallest priority, and among equal
// priorities the most recently enqueued entry leaves first. Every input beat yields
// exactly one result beat carrying a status (enqueued, dequeued, empty error, full
// error), the removed value and priority (zero unless dequeued) and the count held
// afterwards. Each item is first registered; then, once the output register is free
// or being read, all slots compare against the new priority in parallel and shift by
// one place. The next item is taken while a finished result still waits there.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_ctl_cmd w_cmd;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item)
    );

endmodule

/* verif/spq_order_checker.sv */
`timescale 1ns / 100ps

module spq_order_checker
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_mismatches,
    output int        o_pending,
    output int        o_full_hits,
    output int        o_empty_hits
);

    logic signed [31:0] slot_value [CAPACITY];
    logic signed [31:0] slot_prio  [CAPACITY];
    int                 held = 0;
    t_out_item          due_results [$];
    t_out_item          want;
    int                 mismatch_count = 0;
    int                 full_count = 0;
    int                 empty_count = 0;
    int                 result_seq = 0;

    assign o_mismatches = mismatch_count;
    assign o_full_hits  = full_count;
    assign o_empty_hits = empty_count;

    function automatic t_out_item apply_queue_op(input t_in_item it);
        t_out_item r;
        int        pos;
        int        k;
        r = '0;
        if (it.opcode == OP_ENQ) begin
            if (held >= CAPACITY) begin
                r.status = ST_FULL;
                full_count++;
            end else begin
                pos = 0;
                while (pos < held && $signed(slot_prio[pos]) < $signed(it.item_priority)) begin
                    pos++;
                end
                for (k = held; k > pos; k--) begin
                    slot_value[k] = slot_value[k-1];
                    slot_prio[k]  = slot_prio[k-1];
                end
                slot_value[pos] = it.item_value;
                slot_prio[pos]  = it.item_priority;
                held++;
                r.status = ST_ENQ;
            end
        end else begin
            if (held == 0) begin
                r.status = ST_EMPTY;
                empty_count++;
            end else begin
                r.out_value    = slot_value[0];
                r.out_priority = slot_prio[0];
                for (k = 1; k < held; k++) begin
                    slot_value[k-1] = slot_value[k];
                    slot_prio[k-1]  = slot_prio[k];
                end
                held--;
                r.status = ST_DEQ;
            end
        end
        r.held_count = held[HELD_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatch_count++;
        $display("result beat %0d: %s got %0h, expected %0h", result_seq, what, got,
                 exp_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            due_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected beat, status", i_out_item.status, '0);
                end else begin
                    want = due_results.pop_front();
                    if (i_out_item.status !== want.status) begin
                        report_mismatch("status", i_out_item.status, want.status);
                    end
                    if (i_out_item.out_value !== want.out_value) begin
                        report_mismatch("value", i_out_item.out_value, want.out_value);
                    end
                    if (i_out_item.out_priority !== want.out_priority) begin
                        report_mismatch("priority", i_out_item.out_priority,
                                        want.out_priority);
                    end
                    if (i_out_item.held_count !== want.held_count) begin
                        report_mismatch("held count", i_out_item.held_count,
                                        want.held_count);
                    end
                end
                result_seq++;
            end
            if (i_in_valid && i_in_ready) begin
                due_results.push_back(apply_queue_op(i_in_item));
            end
        end
        o_pending <= due_results.size();
    end

endmodule

/* verif/sorted_priority_queue_test.sv */
`timescale 1ns / 100ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      calm = 1'b0;
    int        mismatches;
    int        pending;
    int        full_hits;
    int        empty_hits;
    int        enq_sent = 0;
    int        deq_sent = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sorted_priority_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    spq_order_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_full_hits  (full_hits),
        .o_empty_hits (empty_hits)
    );

    always @(posedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 15);
    end

    function automatic logic signed [31:0] pick_priority();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            // narrow range so ties are common
            2, 3, 4: return $urandom_range(6) - 3;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_beat(input logic op, input logic signed [31:0] value,
                             input logic signed [31:0] prio);
        in_item  <= '{opcode: op, item_value: value, item_priority: prio};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (op == OP_ENQ) begin
            enq_sent++;
        end else begin
            deq_sent++;
        end
        if (!calm && $urandom_range(99) < 15) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int ph;
        int n;
        int enq_pct;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        push_beat(OP_DEQ, 32'sh7fff_ffff, 32'sh8000_0000);
        push_beat(OP_ENQ, 32'sh7fff_ffff, 32'sh7fff_ffff);
        push_beat(OP_ENQ, 32'sh8000_0000, 32'sh8000_0000);
        push_beat(OP_ENQ, 0, 0);
        push_beat(OP_ENQ, -1, -1);
        push_beat(OP_ENQ, 1, 0);
        push_beat(OP_ENQ, 2, 0);
        push_beat(OP_ENQ, 3, 32'sh8000_0000);
        push_beat(OP_ENQ, 4, 32'sh7fff_ffff);
        for (n = 8; n < CAPACITY; n++) begin
            push_beat(OP_ENQ, $urandom(), pick_priority());
        end
        push_beat(OP_ENQ, 32'sh5555_5555, 32'shaaaa_aaaa);
        repeat (7) push_beat(OP_DEQ, -1, -1);

        // phases lean towards filling, balance, then draining
        for (ph = 0; ph < 12; ph++) begin
            calm <= (ph == 4);
            enq_pct = (ph % 3 == 0) ? 80 : (ph % 3 == 1) ? 50 : 20;
            for (n = 0; n < 120; n++) begin
                if ($urandom_range(99) < enq_pct) begin
                    push_beat(OP_ENQ, $urandom(), pick_priority());
                end else begin
                    push_beat(OP_DEQ, $urandom(), $urandom());
                end
            end
            if (ph == 6) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("sent %0d enqueue and %0d dequeue beats, some with ties and extreme priorities",
                 enq_sent, deq_sent);
        $display("full queue refusals: %0d, empty queue refusals: %0d", full_hits, empty_hits);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
